@@ rtl/xcfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfp_pkg: shared types and constants of the frame parser
// Field widths, configuration register indexes and the structs that carry
// frame descriptors and result items between the parser parts.
// ----------------------------------------------------------------------------
package xcfp_pkg;

  // Field widths fixed by the frame format.
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 4;
  localparam int POS_W  = 3;

  // Most results a single frame may yield.
  localparam int RESULT_CAP = 8;

  // Configuration register indexes.
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  // Configuration register reset values.
  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd170;
  localparam logic [LEN_W-1:0]  LIMIT_RESET  = 4'd8;

  // Configuration seen by the front part.
  typedef struct packed {
    logic [BYTE_W-1:0] header_byte;
    logic [LEN_W-1:0]  payload_limit;
  } cfg_t;

  // One accepted frame waiting to be played out.
  typedef struct packed {
    logic [BYTE_W-1:0] cmd;
    logic [LEN_W-1:0]  len;
    logic              bank;
  } desc_t;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0] frame_cmd;
    logic [LEN_W-1:0]  frame_len;
    logic              has_data;
    logic [BYTE_W-1:0] payload_byte;
    logic [POS_W-1:0]  payload_pos;
    logic              last;
  } result_t;

endpackage

@@ rtl/xcfp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfp_ram: payload store
// One write port and one read port with registered read data. Holds two
// banks of payload bytes, one being filled while the other is played out.
// ----------------------------------------------------------------------------
module xcfp_ram #(
  parameter int ENTRIES = 16,
  parameter int ADDR_W  = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [xcfp_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [xcfp_pkg::BYTE_W-1:0] rdata
);

  logic [xcfp_pkg::BYTE_W-1:0] mem [ENTRIES];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/xcfp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfp_front: byte-level frame recognizer
// Hunts for the header, captures command and length, writes payload bytes
// into the current bank and checks the XOR checksum. A good frame is handed
// on as a descriptor and the bank is switched.
// ----------------------------------------------------------------------------
module xcfp_front #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  xcfp_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  input  logic [xcfp_pkg::BYTE_W-1:0] in_byte,
  output logic                        ram_we,
  output logic [ADDR_W-1:0]           ram_waddr,
  output logic [xcfp_pkg::BYTE_W-1:0] ram_wdata,
  output logic                        desc_push,
  output xcfp_pkg::desc_t             desc
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CSUM
  } phase_t;

  localparam logic [xcfp_pkg::LEN_W-1:0] DEPTH_LEN = xcfp_pkg::LEN_W'(DEPTH);

  phase_t                        phase;
  logic [xcfp_pkg::LEN_W-1:0]    bytes_seen;
  logic [xcfp_pkg::BYTE_W-1:0]   held_cmd;
  logic [xcfp_pkg::LEN_W-1:0]    held_len;
  logic [xcfp_pkg::BYTE_W-1:0]   running_xor;
  logic                          wr_bank;
  logic [xcfp_pkg::LEN_W-1:0]    eff_limit;
  logic [xcfp_pkg::LEN_W-1:0]    seen_next;

  // Limit saturated to what the store can hold.
  assign eff_limit = (cfg.payload_limit > DEPTH_LEN) ? DEPTH_LEN : cfg.payload_limit;
  assign seen_next = bytes_seen + xcfp_pkg::LEN_W'(1);

  // Payload bytes go to the current bank at the running position.
  always_comb begin
    ram_we    = in_valid && (phase == PH_DATA);
    ram_wdata = in_byte;
    ram_waddr = ADDR_W'(bytes_seen);
    if (wr_bank) begin
      ram_waddr = ADDR_W'(DEPTH) + ADDR_W'(bytes_seen);
    end
  end

  // A frame whose checksum matches is handed to the queue.
  always_comb begin
    desc_push = in_valid && (phase == PH_CSUM) && (running_xor == in_byte);
    desc.cmd  = held_cmd;
    desc.len  = held_len;
    desc.bank = wr_bank;
  end

  // Parse state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      bytes_seen  <= '0;
      held_cmd    <= '0;
      held_len    <= '0;
      running_xor <= '0;
      wr_bank     <= 1'b0;
    end else if (in_valid) begin
      case (phase)
        PH_CMD: begin
          held_cmd    <= in_byte;
          running_xor <= running_xor ^ in_byte;
          phase       <= PH_LEN;
        end
        PH_LEN: begin
          running_xor <= running_xor ^ in_byte;
          bytes_seen  <= '0;
          if (in_byte > xcfp_pkg::BYTE_W'(eff_limit)) begin
            phase <= PH_HUNT;
          end else begin
            held_len <= in_byte[xcfp_pkg::LEN_W-1:0];
            phase    <= (in_byte == '0) ? PH_CSUM : PH_DATA;
          end
        end
        PH_DATA: begin
          running_xor <= running_xor ^ in_byte;
          bytes_seen  <= seen_next;
          if (seen_next >= held_len) begin
            phase <= PH_CSUM;
          end
        end
        PH_CSUM: begin
          phase <= PH_HUNT;
          if (running_xor == in_byte) begin
            wr_bank <= ~wr_bank;
          end
        end
        default: begin
          phase <= PH_HUNT;
          if (in_byte == cfg.header_byte) begin
            running_xor <= in_byte;
            bytes_seen  <= '0;
            phase       <= PH_CMD;
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/xcfp_frame_q.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfp_frame_q: two-entry descriptor queue
// Holds accepted frames between the recognizer and the result player. Its
// depth matches the number of payload banks, so a full queue means both
// banks are taken.
// ----------------------------------------------------------------------------
module xcfp_frame_q (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  xcfp_pkg::desc_t push_desc,
  input  logic            pop,
  output logic            full,
  output logic            valid,
  output xcfp_pkg::desc_t head
);

  xcfp_pkg::desc_t entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entry[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/xcfp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfp_back: result player
// Walks the oldest accepted frame one payload position per cycle unless the
// output stalls, reads the store, delivers results via an output register.
// ----------------------------------------------------------------------------
module xcfp_back #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        desc_valid,
  input  xcfp_pkg::desc_t             desc,
  output logic                        desc_pop,
  output logic                        ram_re,
  output logic [ADDR_W-1:0]           ram_raddr,
  input  logic [xcfp_pkg::BYTE_W-1:0] ram_rdata,
  input  logic                        out_pop,
  output logic                        out_valid,
  output xcfp_pkg::result_t           out_item
);

  logic [xcfp_pkg::POS_W-1:0] idx;
  logic                       issue;
  logic                       issue_last;
  logic                       rd_valid;
  logic                       rd_move;
  xcfp_pkg::result_t          rd_item;
  xcfp_pkg::result_t          issue_item;
  xcfp_pkg::result_t          out_next;

  // Read stage advances when the output register is free or being emptied.
  assign rd_move = rd_valid && (!out_valid || out_pop);
  assign issue   = desc_valid && (!rd_valid || rd_move);

  assign issue_last = (desc.len == '0) ||
                      (({1'b0, idx} + xcfp_pkg::LEN_W'(1)) == desc.len);
  assign desc_pop   = issue && issue_last;

  // Store address and the fields known at issue time.
  always_comb begin
    ram_re    = issue;
    ram_raddr = ADDR_W'(idx);
    if (desc.bank) begin
      ram_raddr = ADDR_W'(DEPTH) + ADDR_W'(idx);
    end
    issue_item.frame_cmd    = desc.cmd;
    issue_item.frame_len    = desc.len;
    issue_item.has_data     = (desc.len != '0);
    issue_item.payload_byte = '0;
    issue_item.payload_pos  = idx;
    issue_item.last         = issue_last;
  end

  // Position counter within the current frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (issue) begin
      idx <= issue_last ? '0 : idx + xcfp_pkg::POS_W'(1);
    end
  end

  // Read stage and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (rd_move) begin
        rd_valid <= 1'b0;
      end
      if (rd_move) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The store data fills the payload byte of a frame that carries data.
  always_comb begin
    out_next              = rd_item;
    out_next.payload_byte = rd_item.has_data ? ram_rdata : '0;
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_item <= issue_item;
    end
    if (rd_move) begin
      out_item <= out_next;
    end
  end

endmodule

@@ rtl/xor_checked_frame_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_frame_parser_core: length-prefixed frame parser, XOR checksum
// The first result of a good frame passes the descriptor queue, read stage
// and output register after its checksum byte is accepted. Throughput: one
// byte per cycle unless full, results one per cycle while pop is held; full
// rises while two good frames hold both payload banks. Reset clears parse
// state, queue and output valid; header 170, limit 8; store not cleared.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser_core #(
  parameter int MAX_PAYLOAD = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [xcfp_pkg::BYTE_W-1:0] rx_byte,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [xcfp_pkg::BYTE_W-1:0] cfg_data,
  output logic                        empty,
  input  logic                        pop,
  output logic [xcfp_pkg::BYTE_W-1:0] frame_cmd,
  output logic [xcfp_pkg::LEN_W-1:0]  frame_len,
  output logic                        has_data,
  output logic [xcfp_pkg::BYTE_W-1:0] payload_byte,
  output logic [xcfp_pkg::POS_W-1:0]  payload_pos,
  output logic                        last
);

  // Bytes one bank must hold, and the two-bank store size.
  localparam int DEPTH   = (MAX_PAYLOAD < xcfp_pkg::RESULT_CAP) ? MAX_PAYLOAD
                                                                : xcfp_pkg::RESULT_CAP;
  localparam int ENTRIES = 2 * DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);

  xcfp_pkg::cfg_t              cfg;
  logic                        in_valid;
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic [xcfp_pkg::BYTE_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [ADDR_W-1:0]           ram_raddr;
  logic [xcfp_pkg::BYTE_W-1:0] ram_rdata;
  logic                        desc_push;
  xcfp_pkg::desc_t             push_desc;
  logic                        desc_pop;
  logic                        desc_valid;
  xcfp_pkg::desc_t             head_desc;
  logic                        out_valid;
  logic                        out_pop;
  xcfp_pkg::result_t           out_item;

  assign in_valid = push && !full;
  assign out_pop  = pop && out_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte   <= xcfp_pkg::HEADER_RESET;
      cfg.payload_limit <= xcfp_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        xcfp_pkg::REG_HEADER: cfg.header_byte   <= cfg_data;
        xcfp_pkg::REG_LIMIT:  cfg.payload_limit <= cfg_data[xcfp_pkg::LEN_W-1:0];
        default:              cfg               <= cfg;
      endcase
    end
  end

  xcfp_front #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_byte   (rx_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .desc_push (desc_push),
    .desc      (push_desc)
  );

  xcfp_ram #(
    .ENTRIES (ENTRIES),
    .ADDR_W  (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  xcfp_frame_q u_frame_q (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_push),
    .push_desc (push_desc),
    .pop       (desc_pop),
    .full      (full),
    .valid     (desc_valid),
    .head      (head_desc)
  );

  xcfp_back #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc       (head_desc),
    .desc_pop   (desc_pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_pop    (out_pop),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

  // Result ports.
  assign empty        = !out_valid;
  assign frame_cmd    = out_item.frame_cmd;
  assign frame_len    = out_item.frame_len;
  assign has_data     = out_item.has_data;
  assign payload_byte = out_item.payload_byte;
  assign payload_pos  = out_item.payload_pos;
  assign last         = out_item.last;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the XOR-checked frame parser
// Feeds received bytes through the push/full side, mirrors the parser in a
// small scoreboard class and compares every popped result with the oldest
// expected one. The byte stream mixes well-formed frames with random content,
// bad checksums, oversized lengths, truncated frames and line noise, under
// several header and payload-limit settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FRAME_MAX     = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int PHASE_QUOTA   = 28;

  // Parser phases, in the order a frame walks through them.
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CSUM
  } parse_phase_t;

  // Mirror of the parser plus the queue of results it still owes.
  class frame_result_tracker;
    logic [xcfp_pkg::BYTE_W-1:0] header_byte;
    logic [xcfp_pkg::LEN_W-1:0]  payload_limit;
    parse_phase_t                phase;
    logic [xcfp_pkg::BYTE_W-1:0] payload_store [FRAME_MAX];
    int                          bytes_seen;
    logic [xcfp_pkg::BYTE_W-1:0] held_cmd;
    logic [xcfp_pkg::LEN_W-1:0]  held_len;
    logic [xcfp_pkg::BYTE_W-1:0] running_xor;
    xcfp_pkg::result_t           owed_results [$];
    int                          errors;
    int                          results_checked;
    int                          frames_passed;

    function new();
      header_byte     = xcfp_pkg::HEADER_RESET;
      payload_limit   = xcfp_pkg::LIMIT_RESET;
      phase           = PH_HUNT;
      bytes_seen      = 0;
      held_cmd        = '0;
      held_len        = '0;
      running_xor     = '0;
      errors          = 0;
      results_checked = 0;
      frames_passed   = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Limit values above what one frame may yield act as the largest size.
    function int effective_limit();
      int lim;
      lim = int'(payload_limit);
      if (lim > FRAME_MAX) lim = FRAME_MAX;
      if (lim > xcfp_pkg::RESULT_CAP) lim = xcfp_pkg::RESULT_CAP;
      return lim;
    endfunction

    function void write_reg(logic idx, logic [xcfp_pkg::BYTE_W-1:0] data);
      if (idx == xcfp_pkg::REG_HEADER) begin
        header_byte = data;
      end else begin
        payload_limit = data[xcfp_pkg::LEN_W-1:0];
      end
    endfunction

    // Advance the mirror by one accepted byte and queue what it yields.
    function void note_rx_byte(logic [xcfp_pkg::BYTE_W-1:0] b);
      xcfp_pkg::result_t r;
      case (phase)
        PH_CMD: begin
          held_cmd    = b;
          running_xor = running_xor ^ b;
          phase       = PH_LEN;
        end
        PH_LEN: begin
          running_xor = running_xor ^ b;
          bytes_seen  = 0;
          if (int'(b) > effective_limit()) begin
            // Oversized length: back to hunting, this byte is not a header.
            phase = PH_HUNT;
          end else begin
            held_len = b[xcfp_pkg::LEN_W-1:0];
            phase    = (b == 0) ? PH_CSUM : PH_DATA;
          end
        end
        PH_DATA: begin
          if (bytes_seen < held_len && bytes_seen < FRAME_MAX) begin
            payload_store[bytes_seen] = b;
            running_xor               = running_xor ^ b;
            bytes_seen++;
          end
          if (bytes_seen >= held_len) phase = PH_CSUM;
        end
        PH_CSUM: begin
          // A bad checksum drops the frame; the byte is not a header either.
          phase = PH_HUNT;
          if (running_xor == b) begin
            frames_passed++;
            if (held_len == 0) begin
              r              = '0;
              r.frame_cmd    = held_cmd;
              r.last         = 1'b1;
              owed_results.push_back(r);
            end else begin
              for (int i = 0; i < held_len && i < FRAME_MAX && i < xcfp_pkg::RESULT_CAP;
                   i++) begin
                r.frame_cmd    = held_cmd;
                r.frame_len    = held_len;
                r.has_data     = 1'b1;
                r.payload_byte = payload_store[i];
                r.payload_pos  = xcfp_pkg::POS_W'(i);
                r.last         = (i + 1 == held_len);
                owed_results.push_back(r);
              end
            end
          end
        end
        default: begin
          phase = PH_HUNT;
          if (b == header_byte) begin
            running_xor = b;
            bytes_seen  = 0;
            phase       = PH_CMD;
          end
        end
      endcase
    endfunction

    task report(string what);
      $display("tb_top: mismatch: %s", what);
      errors++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) begin
        report($sformatf("result %0d field %s got %0h, wanted %0h",
                         results_checked, name, got, want));
      end
    endtask

    task check_result(xcfp_pkg::result_t got);
      xcfp_pkg::result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result cmd %0h len %0d pos %0d",
                         got.frame_cmd, got.frame_len, got.payload_pos));
      end else begin
        want = owed_results.pop_front();
        compare_field("frame_cmd", int'(got.frame_cmd), int'(want.frame_cmd));
        compare_field("frame_len", int'(got.frame_len), int'(want.frame_len));
        compare_field("has_data", int'(got.has_data), int'(want.has_data));
        compare_field("payload_byte", int'(got.payload_byte), int'(want.payload_byte));
        compare_field("payload_pos", int'(got.payload_pos), int'(want.payload_pos));
        compare_field("last", int'(got.last), int'(want.last));
      end
      results_checked++;
    endtask
  endclass

  logic                        clk;
  logic                        rst;
  logic                        push;
  logic                        full;
  logic [xcfp_pkg::BYTE_W-1:0] rx_byte;
  logic                        cfg_we;
  logic                        cfg_index;
  logic [xcfp_pkg::BYTE_W-1:0] cfg_data;
  logic                        empty;
  logic                        pop;
  logic [xcfp_pkg::BYTE_W-1:0] frame_cmd;
  logic [xcfp_pkg::LEN_W-1:0]  frame_len;
  logic                        has_data;
  logic [xcfp_pkg::BYTE_W-1:0] payload_byte;
  logic [xcfp_pkg::POS_W-1:0]  payload_pos;
  logic                        last;

  frame_result_tracker tracker;
  bit                  idle_on = 1'b1;
  int                  bytes_sent = 0;
  int                  frame_bytes = 0;
  int                  cycles = 0;

  xor_checked_frame_parser_core #(
    .MAX_PAYLOAD(FRAME_MAX)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .rx_byte     (rx_byte),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .empty       (empty),
    .pop         (pop),
    .frame_cmd   (frame_cmd),
    .frame_len   (frame_len),
    .has_data    (has_data),
    .payload_byte(payload_byte),
    .payload_pos (payload_pos),
    .last        (last)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Result side: pop with random stall bursts while idling is enabled.
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  // Check every result item taken from the block.
  always @(posedge clk) begin : result_monitor
    xcfp_pkg::result_t got;
    if (!rst && pop && !empty) begin
      got.frame_cmd    = frame_cmd;
      got.frame_len    = frame_len;
      got.has_data     = has_data;
      got.payload_byte = payload_byte;
      got.payload_pos  = payload_pos;
      got.last         = last;
      tracker.check_result(got);
    end
  end

  // Offer one byte, wait until it is taken, then maybe idle for a while.
  task automatic push_byte(input logic [xcfp_pkg::BYTE_W-1:0] b);
    push    <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.note_rx_byte(b);
    bytes_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Stop sending until every owed result has come, then let the block settle.
  task automatic drain();
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers; only called with the block drained.
  task automatic write_config(input logic [xcfp_pkg::BYTE_W-1:0] hdr,
                              input logic [xcfp_pkg::BYTE_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= xcfp_pkg::REG_HEADER;
    cfg_data  <= hdr;
    @(posedge clk);
    tracker.write_reg(xcfp_pkg::REG_HEADER, hdr);
    cfg_index <= xcfp_pkg::REG_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    tracker.write_reg(xcfp_pkg::REG_LIMIT, lim);
    cfg_we <= 1'b0;
  endtask

  // A complete frame under the current header; the checksum may be spoiled.
  // With edge_payload set the payload alternates all-zero and all-one bytes.
  task automatic send_frame(input logic [xcfp_pkg::BYTE_W-1:0] cmd, input int len,
                            input bit corrupt, input bit edge_payload);
    logic [xcfp_pkg::BYTE_W-1:0] hdr;
    logic [xcfp_pkg::BYTE_W-1:0] sum;
    logic [xcfp_pkg::BYTE_W-1:0] b;
    hdr = tracker.header_byte;
    sum = hdr ^ cmd ^ xcfp_pkg::BYTE_W'(len);
    push_byte(hdr);
    push_byte(cmd);
    push_byte(xcfp_pkg::BYTE_W'(len));
    for (int k = 0; k < len; k++) begin
      b   = edge_payload ? ((k % 2 == 0) ? 8'h00 : 8'hFF) : xcfp_pkg::BYTE_W'($urandom);
      sum = sum ^ b;
      push_byte(b);
    end
    if (corrupt) sum = sum ^ xcfp_pkg::BYTE_W'($urandom_range(1, 255));
    push_byte(sum);
    frame_bytes += len + 4;
  endtask

  function automatic logic [xcfp_pkg::BYTE_W-1:0] non_header_byte();
    logic [xcfp_pkg::BYTE_W-1:0] b;
    do b = xcfp_pkg::BYTE_W'($urandom); while (b == tracker.header_byte);
    return b;
  endfunction

  // Random traffic, mostly well-formed frames, until the quota of frame bytes.
  task automatic run_random_phase(input int quota);
    int target;
    int pick;
    int lim;
    int len;
    target = frame_bytes + quota;
    while (frame_bytes < target) begin
      // Flush any half-parsed frame so the next frame starts aligned.
      while (tracker.phase != PH_HUNT) push_byte(non_header_byte());
      pick = $urandom_range(0, 99);
      lim  = tracker.effective_limit();
      if (pick < 75) begin
        send_frame(xcfp_pkg::BYTE_W'($urandom), $urandom_range(0, lim),
                   $urandom_range(0, 99) < 15, 1'b0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) push_byte(non_header_byte());
      end else if (pick < 93) begin
        // Length over the limit.
        push_byte(tracker.header_byte);
        push_byte(xcfp_pkg::BYTE_W'($urandom));
        push_byte(xcfp_pkg::BYTE_W'($urandom_range(lim + 1, 255)));
        frame_bytes += 3;
      end else begin
        // Truncated frame: cut off before its checksum.
        push_byte(tracker.header_byte);
        push_byte(xcfp_pkg::BYTE_W'($urandom));
        frame_bytes += 2;
        if (lim > 0) begin
          len = $urandom_range(1, lim);
          push_byte(xcfp_pkg::BYTE_W'(len));
          repeat ($urandom_range(0, len - 1)) push_byte(xcfp_pkg::BYTE_W'($urandom));
          frame_bytes += 1;
        end
      end
    end
  endtask

  // Stimulus.
  initial begin
    tracker   = new();
    rst       = 1'b1;
    push      = 1'b0;
    rx_byte   = '0;
    cfg_we    = 1'b0;
    cfg_index = xcfp_pkg::REG_HEADER;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty frame, then the longest frame with extreme command and payload.
    send_frame(8'h00, 0, 1'b0, 1'b0);
    send_frame(8'hFF, FRAME_MAX, 1'b0, 1'b1);
    // Oversized length whose value equals the header: it must not restart.
    push_byte(8'hAA);
    push_byte(8'h01);
    push_byte(8'hAA);
    // Bad checksum that equals the header: dropped and not taken as a header.
    push_byte(8'hAA);
    push_byte(8'h02);
    push_byte(8'h00);
    push_byte(8'hAA);
    // Header and limit changed in mid-frame: the checksum keeps the old header.
    push_byte(8'hAA);
    push_byte(8'h05);
    drain();
    write_config(8'hFF, 8'h00);
    push_byte(8'h00);
    push_byte(8'hAA ^ 8'h05);

    // Random phases under different settings; the last one without stalls.
    drain();
    write_config(8'h00, 8'h08);
    run_random_phase(PHASE_QUOTA);
    drain();
    write_config(8'hFF, 8'hFF);
    run_random_phase(PHASE_QUOTA);
    drain();
    write_config(xcfp_pkg::BYTE_W'($urandom), xcfp_pkg::BYTE_W'($urandom_range(0, 3)));
    run_random_phase(PHASE_QUOTA);
    drain();
    idle_on = 1'b0;
    write_config(xcfp_pkg::BYTE_W'($urandom), xcfp_pkg::BYTE_W'($urandom));
    run_random_phase(PHASE_QUOTA);

    // Wrap up once every owed result is in.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb_top: %0d bytes pushed, %0d good frames, %0d results checked",
             bytes_sent, tracker.frames_passed, tracker.results_checked);
    $display("tb_top: %0d mismatches over four header/limit settings",
             tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/xcfp_pkg.sv
rtl/xcfp_ram.sv
rtl/xcfp_front.sv
rtl/xcfp_frame_q.sv
rtl/xcfp_back.sv
rtl/xor_checked_frame_parser_core.sv
test/tb_top.sv
